// ----- rtl/core/ppc_pkg.sv -----
// ppc_pkg: widths, constants and pipeline types for the preset position pd controller
// no dependencies; imported by preset_position_pd_controller_unit

package ppc_pkg;

  localparam int POS_W       = 21;           // positions in whole degrees
  localparam int ERR_W       = POS_W + 1;    // target minus measured, exact
  localparam int DERIV_W     = ERR_W + 1;
  localparam int POWER_W     = DERIV_W + 4;  // 2*err + 8*deriv + gravity
  localparam int CLAMP_W     = 12;           // holds +/-1270
  localparam int MAG_W       = CLAMP_W - 1;
  localparam int DRIVE_W     = 8;
  localparam int QUOT_W      = DRIVE_W - 1;
  localparam int SLOT_W      = 2;
  localparam int NUM_PRESETS = 4;
  localparam int IDX_W       = 3;

  localparam int DATA_IN_W   = 48;           // two positions, zero padded to bytes
  localparam int USER_IN_W   = 6;
  localparam int DATA_OUT_W  = 8;
  localparam int USER_OUT_W  = 1;

  localparam logic signed [POS_W-1:0] PRESET_RST_0 = 21'sd0;
  localparam logic signed [POS_W-1:0] PRESET_RST_1 = 21'sd550;
  localparam logic signed [POS_W-1:0] PRESET_RST_2 = 21'sd5800;
  localparam logic signed [POS_W-1:0] PRESET_RST_3 = 21'sd9650;

  localparam logic signed [ERR_W-1:0]   BRAKE_BAND     = 22'sd20;
  localparam logic signed [POWER_W-1:0] POWER_LIMIT    = 27'sd1270;
  localparam logic signed [POWER_W-1:0] GRAVITY_TENTHS = 27'sd300;

  // divide by ten: floor(a * 1639 / 2^14) is exact for 0 <= a <= 1270
  localparam logic [MAG_W-1:0] RECIP_TEN = 11'd1639;
  localparam int               RECIP_SH  = 14;
  localparam int               PROD_W    = 2 * MAG_W;

  localparam logic [IDX_W-1:0]  PRESET_NONE = 3'd4;
  localparam logic [SLOT_W-1:0] SLOT_MAX    = 2'd3;
  localparam logic [SLOT_W-1:0] SLOT_MIN    = 2'd0;

  // first stage result handed to the scaling stage
  typedef struct packed {
    logic signed [POWER_W-1:0] power;
    logic                      brake;
  } stage1_t;

endpackage

// ----- rtl/core/preset_position_pd_controller_unit.sv -----
// preset_position_pd_controller_unit: target selection, pd error terms and drive scaling
// depends on ppc_pkg for widths, constants and the stage type
//
//  channel  | direction | payload (lowest bit first)
//  ---------+-----------+----------------------------------------------------------------
//  s_axis   | in        | tdata: custom_target, measured_position; tuser: use_custom,
//           |           |   preset_index, step_up, step_down
//  m_axis   | out       | tdata: drive; tuser: brake
//  cfg      | in        | cfg_index selects preset_position_0..3, cfg_data the new value
//
// two register stages: the first holds power and brake, the second is the output word.
// a word is accepted every cycle while the output is not stalled; stage1 captures it at
// the accepting edge, and the output register then takes it and raises m_axis_tvalid.
// the error register and preset slot update as the word is accepted, so ticks chain
// back to back. m_axis_tready low stalls both stages and drops s_axis_tready once full.
// rst clears valids, slot, target, previous error and reloads the preset values.

module preset_position_pd_controller_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // custom_target [20:0], measured_position [41:21], zero [47:42]
  input  logic [ppc_pkg::DATA_IN_W-1:0]  s_axis_tdata,
  // use_custom [0], preset_index [3:1], step_up [4], step_down [5]
  input  logic [ppc_pkg::USER_IN_W-1:0]  s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // drive [7:0]
  output logic [ppc_pkg::DATA_OUT_W-1:0] m_axis_tdata,
  // brake [0]
  output logic [ppc_pkg::USER_OUT_W-1:0] m_axis_tuser,
  input  logic                           cfg_we,
  input  logic [ppc_pkg::SLOT_W-1:0]     cfg_index,
  input  logic [ppc_pkg::POS_W-1:0]      cfg_data
);
  import ppc_pkg::*;

  // input unpacking
  logic                    use_custom;
  logic [IDX_W-1:0]        preset_index;
  logic                    step_up;
  logic                    step_down;
  logic signed [POS_W-1:0] custom_target;
  logic signed [POS_W-1:0] measured_position;

  assign custom_target     = s_axis_tdata[POS_W-1:0];
  assign measured_position = s_axis_tdata[2*POS_W-1:POS_W];
  assign use_custom        = s_axis_tuser[0];
  assign preset_index      = s_axis_tuser[IDX_W:1];
  assign step_up           = s_axis_tuser[IDX_W+1];
  assign step_down         = s_axis_tuser[IDX_W+2];

  // state
  logic signed [POS_W-1:0] preset_position [NUM_PRESETS];
  logic [SLOT_W-1:0]       preset_slot, preset_slot_next;
  logic signed [POS_W-1:0] target_position, target_position_next;
  logic signed [ERR_W-1:0] previous_error;

  logic    v1, v2;
  stage1_t stage1, stage1_next;
  logic signed [DRIVE_W-1:0] drive;
  logic                      brake;

  logic en1, en2, s_fire;

  assign en2           = !v2 || m_axis_tready;
  assign en1           = !v1 || en2;
  assign s_axis_tready = en1;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  // preset registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_PRESETS; i++) begin
        case (i % NUM_PRESETS)
          1:       preset_position[i] <= PRESET_RST_1;
          2:       preset_position[i] <= PRESET_RST_2;
          3:       preset_position[i] <= PRESET_RST_3;
          default: preset_position[i] <= PRESET_RST_0;
        endcase
      end
    end else if (cfg_we) begin
      preset_position[cfg_index] <= $signed(cfg_data);
    end
  end

  // target selection: custom, then direct slot, then up over down
  always_comb begin
    preset_slot_next     = preset_slot;
    target_position_next = target_position;
    if (use_custom) begin
      target_position_next = custom_target;
    end else if (preset_index < PRESET_NONE) begin
      preset_slot_next     = preset_index[SLOT_W-1:0];
      target_position_next = preset_position[preset_index[SLOT_W-1:0]];
    end else if (step_up) begin
      preset_slot_next     = (preset_slot == SLOT_MAX) ? preset_slot : preset_slot + 2'd1;
      target_position_next = preset_position[preset_slot_next];
    end else if (step_down) begin
      preset_slot_next     = (preset_slot == SLOT_MIN) ? preset_slot : preset_slot - 2'd1;
      target_position_next = preset_position[preset_slot_next];
    end
  end

  // error terms and raw power in tenths
  logic signed [ERR_W-1:0]   error;
  logic signed [DERIV_W-1:0] deriv;

  always_comb begin
    error = ERR_W'(target_position_next) - ERR_W'(measured_position);
    deriv = DERIV_W'(error) - DERIV_W'(previous_error);
    stage1_next.power = (POWER_W'(error) <<< 1) + (POWER_W'(deriv) <<< 3)
                      + ((target_position_next > 0) ? GRAVITY_TENTHS : '0);
    stage1_next.brake = (error < BRAKE_BAND) && (error > -BRAKE_BAND);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      preset_slot     <= '0;
      target_position <= '0;
      previous_error  <= '0;
      v1              <= 1'b0;
    end else begin
      if (s_fire) begin
        preset_slot     <= preset_slot_next;
        target_position <= target_position_next;
        previous_error  <= error;
      end
      if (en1) begin
        v1 <= s_fire;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      stage1 <= stage1_next;
    end
  end

  // clamp, magnitude, divide by ten toward zero
  logic signed [CLAMP_W-1:0] clamped;
  logic [MAG_W-1:0]          magnitude;
  logic [PROD_W-1:0]         product;
  logic [QUOT_W-1:0]         quotient;
  logic signed [DRIVE_W-1:0] drive_next;

  always_comb begin
    if (stage1.power > POWER_LIMIT) begin
      clamped = CLAMP_W'(POWER_LIMIT);
    end else if (stage1.power < -POWER_LIMIT) begin
      clamped = CLAMP_W'(-POWER_LIMIT);
    end else begin
      clamped = CLAMP_W'(stage1.power);
    end
    magnitude = clamped[CLAMP_W-1] ? MAG_W'(-clamped) : clamped[MAG_W-1:0];
    product   = PROD_W'(magnitude) * PROD_W'(RECIP_TEN);
    quotient  = product[RECIP_SH+QUOT_W-1:RECIP_SH];
    if (stage1.brake) begin
      drive_next = '0;
    end else if (clamped[CLAMP_W-1]) begin
      drive_next = -$signed({1'b0, quotient});
    end else begin
      drive_next = $signed({1'b0, quotient});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en2 && v1) begin
      drive <= drive_next;
      brake <= stage1.brake;
    end
  end

  assign m_axis_tvalid = v2;
  assign m_axis_tdata  = drive;
  assign m_axis_tuser  = brake;

  // checks
  a_brake_zero_drive: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && brake |-> drive == '0)
    else $error("brake with nonzero drive");

  a_drive_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> drive != {1'b1, {(DRIVE_W-1){1'b0}}})
    else $error("drive outside symmetric range");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !v1 && !v2)
    else $error("pipeline not empty after reset");

  a_custom_keeps_slot: assert property (@(posedge clk) disable iff (rst)
    s_fire && use_custom |=> $stable(preset_slot))
    else $error("slot moved on custom target");

endmodule

// ----- tb/preset_position_pd_controller_unit_tb.sv -----
// preset_position_pd_controller_unit_tb: stream-level test of the preset position pd controller
// predicts drive and brake for every accepted tick and checks them in order on m_axis
// depends on ppc_pkg and preset_position_pd_controller_unit

module preset_position_pd_controller_unit_tb;
  import ppc_pkg::*;

  typedef enum logic [1:0] {
    REG_PRESET_0 = 2'd0,
    REG_PRESET_1 = 2'd1,
    REG_PRESET_2 = 2'd2,
    REG_PRESET_3 = 2'd3
  } preset_reg_e;

  typedef struct {
    logic                    use_custom;
    logic signed [POS_W-1:0] custom_target;
    logic [IDX_W-1:0]        preset_index;
    logic                    step_up;
    logic                    step_down;
    logic signed [POS_W-1:0] measured;
  } tick_t;

  typedef struct {
    logic signed [DRIVE_W-1:0] drive;
    logic                      brake;
  } drive_word_t;

  localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
  localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};
  localparam logic [IDX_W-1:0]        IDX_0   = 3'd0;
  localparam logic [IDX_W-1:0]        IDX_1   = 3'd1;
  localparam logic [IDX_W-1:0]        IDX_2   = 3'd2;
  localparam logic [IDX_W-1:0]        IDX_3   = 3'd3;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    s_axis_tvalid = 1'b0;
  logic                    s_axis_tready;
  logic [DATA_IN_W-1:0]    s_axis_tdata = '0;
  logic [USER_IN_W-1:0]    s_axis_tuser = '0;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  logic [DATA_OUT_W-1:0]   m_axis_tdata;
  logic [USER_OUT_W-1:0]   m_axis_tuser;
  logic                    cfg_we = 1'b0;
  logic [1:0]              cfg_index = '0;
  logic [POS_W-1:0]        cfg_data = '0;

  // controller state as the block should hold it
  logic signed [POS_W-1:0] preset_pos [NUM_PRESETS];
  logic [SLOT_W-1:0]       cur_slot;
  logic signed [POS_W-1:0] target_pos;
  logic signed [ERR_W-1:0] prev_err;

  drive_word_t drive_due_q [$];
  int          mismatch_count = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          hold_off_left = 0;

  always #6 clk = ~clk;

  preset_position_pd_controller_unit u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  function automatic void clear_controller();
    preset_pos[0] = PRESET_RST_0;
    preset_pos[1] = PRESET_RST_1;
    preset_pos[2] = PRESET_RST_2;
    preset_pos[3] = PRESET_RST_3;
    cur_slot      = SLOT_MIN;
    target_pos    = '0;
    prev_err      = '0;
  endfunction

  function automatic void predict_drive(input tick_t t);
    logic signed [ERR_W-1:0]   err;
    logic signed [DERIV_W-1:0] deriv;
    logic signed [POWER_W-1:0] power;
    int                        quot;
    drive_word_t               w;
    if (t.use_custom) begin
      target_pos = t.custom_target;
    end else if (t.preset_index < NUM_PRESETS) begin
      cur_slot   = t.preset_index[SLOT_W-1:0];
      target_pos = preset_pos[cur_slot];
    end else if (t.step_up) begin
      if (cur_slot != SLOT_MAX) cur_slot = cur_slot + 1'b1;
      target_pos = preset_pos[cur_slot];
    end else if (t.step_down) begin
      if (cur_slot != SLOT_MIN) cur_slot = cur_slot - 1'b1;
      target_pos = preset_pos[cur_slot];
    end
    err   = ERR_W'(target_pos) - ERR_W'(t.measured);
    deriv = DERIV_W'(err) - DERIV_W'(prev_err);
    prev_err = err;
    // power in tenths of a drive unit
    power = POWER_W'(2 * err + 8 * deriv);
    if (target_pos > 0) power = power + GRAVITY_TENTHS;
    if (power > POWER_LIMIT) power = POWER_LIMIT;
    if (power < -POWER_LIMIT) power = -POWER_LIMIT;
    w.brake = (err < BRAKE_BAND) && (err > -BRAKE_BAND);
    quot    = power / 10;
    w.drive = w.brake ? '0 : quot[DRIVE_W-1:0];
    drive_due_q.push_back(w);
  endfunction

  function automatic tick_t make_tick(input logic use_custom, input int custom_target,
                                      input logic [IDX_W-1:0] preset_index,
                                      input logic step_up, input logic step_down,
                                      input int measured);
    tick_t t;
    t.use_custom    = use_custom;
    t.custom_target = custom_target[POS_W-1:0];
    t.preset_index  = preset_index;
    t.step_up       = step_up;
    t.step_down     = step_down;
    t.measured      = measured[POS_W-1:0];
    return t;
  endfunction

  function automatic logic signed [POS_W-1:0] random_position();
    int pick;
    pick = $urandom_range(99);
    if (pick < 25) return POS_W'($urandom);
    if (pick < 30) return POS_MAX;
    if (pick < 35) return POS_MIN;
    return POS_W'($urandom_range(14000) - 2000);
  endfunction

  // mostly ticks whose measurement sits near the target so brake and small drives occur
  function automatic tick_t random_tick();
    tick_t                   t;
    logic signed [POS_W-1:0] base;
    int                      pick;
    t.use_custom    = ($urandom_range(7) == 0);
    t.custom_target = random_position();
    t.preset_index  = ($urandom_range(1) == 0) ? IDX_W'($urandom_range(3))
                                               : IDX_W'($urandom_range(7, 4));
    t.step_up       = ($urandom_range(2) == 0);
    t.step_down     = ($urandom_range(2) == 0);
    if (t.use_custom) base = t.custom_target;
    else if (t.preset_index < NUM_PRESETS) base = preset_pos[t.preset_index[SLOT_W-1:0]];
    else base = target_pos;
    pick = $urandom_range(99);
    if (pick < 65) t.measured = base + POS_W'($urandom_range(80) - 40);
    else if (pick < 90) t.measured = base + POS_W'($urandom_range(40000) - 20000);
    else t.measured = POS_W'($urandom);
    return t;
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_tick(input tick_t t);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(DATA_IN_W - 2 * POS_W){1'b0}}, t.measured, t.custom_target};
    s_axis_tuser  <= {t.step_down, t.step_up, t.preset_index, t.use_custom};
    do @(posedge clk); while (!s_axis_tready);
    predict_drive(t);
    @(negedge clk);
  endtask

  task automatic wait_for_drain();
    s_axis_tvalid <= 1'b0;
    @(negedge clk);
    while (drive_due_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // only while the block is idle
  task automatic write_preset(input preset_reg_e idx, input logic signed [POS_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    preset_pos[idx] = value;
    @(negedge clk);
  endtask

  // receiver: random stalls, or a counted hold-off when one is requested
  always @(negedge clk) begin
    if (hold_off_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_off_left--;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    drive_word_t due;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (drive_due_q.size() == 0) begin
        $error("result word with nothing outstanding: drive %0d brake %0b",
               $signed(m_axis_tdata), m_axis_tuser[0]);
        mismatch_count++;
      end else begin
        due = drive_due_q.pop_front();
        if (m_axis_tdata !== due.drive) begin
          $error("drive: expected %0d, got %0d", due.drive, $signed(m_axis_tdata));
          mismatch_count++;
        end
        if (m_axis_tuser[0] !== due.brake) begin
          $error("brake: expected %0b, got %0b", due.brake, m_axis_tuser[0]);
          mismatch_count++;
        end
      end
    end
  end

  task automatic test_selection_and_brake();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    // reset presets, slot stepping with saturation, brake band edges
    send_tick(make_tick(1'b0, 0, PRESET_NONE, 1'b0, 1'b0, 0));
    send_tick(make_tick(1'b0, 0, IDX_1, 1'b0, 1'b0, 0));
    send_tick(make_tick(1'b0, 0, IDX_2, 1'b0, 1'b0, 100));
    send_tick(make_tick(1'b0, 0, IDX_3, 1'b0, 1'b0, 9000));
    send_tick(make_tick(1'b0, 0, PRESET_NONE, 1'b1, 1'b0, 9650));
    send_tick(make_tick(1'b0, 0, PRESET_NONE, 1'b1, 1'b1, 9640));
    send_tick(make_tick(1'b0, 0, PRESET_NONE, 1'b0, 1'b1, 5819));
    send_tick(make_tick(1'b0, 0, PRESET_NONE, 1'b0, 1'b1, 530));
    send_tick(make_tick(1'b0, 0, PRESET_NONE, 1'b0, 1'b1, -20));
    send_tick(make_tick(1'b0, 0, PRESET_NONE, 1'b0, 1'b1, 19));
    send_tick(make_tick(1'b0, 0, IDX_0, 1'b0, 1'b0, 20));
    // custom wins over preset and steps, slot stays put
    send_tick(make_tick(1'b1, POS_MAX, IDX_3, 1'b1, 1'b0, POS_MIN));
    send_tick(make_tick(1'b1, POS_MIN, PRESET_NONE, 1'b0, 1'b1, POS_MAX));
    send_tick(make_tick(1'b0, -1, PRESET_NONE, 1'b1, 1'b0, 540));
    send_tick(make_tick(1'b0, 0, 3'd5, 1'b0, 1'b0, 550));
    send_tick(make_tick(1'b0, -1, 3'd6, 1'b0, 1'b0, 500));
    send_tick(make_tick(1'b0, 0, 3'd7, 1'b0, 1'b0, 560));
    send_tick(make_tick(1'b1, 100, PRESET_NONE, 1'b0, 1'b0, 70));
    send_tick(make_tick(1'b1, -100, PRESET_NONE, 1'b0, 1'b0, -70));
    send_tick(make_tick(1'b1, 0, PRESET_NONE, 1'b0, 1'b0, -19));
    wait_for_drain();
  endtask

  task automatic test_preset_extremes();
    write_preset(REG_PRESET_0, POS_MAX);
    write_preset(REG_PRESET_1, POS_MIN);
    write_preset(REG_PRESET_2, -1);
    write_preset(REG_PRESET_3, 1);
    send_tick(make_tick(1'b0, 0, IDX_0, 1'b0, 1'b0, POS_MIN));
    send_tick(make_tick(1'b0, 0, IDX_1, 1'b0, 1'b0, POS_MAX));
    send_tick(make_tick(1'b0, 0, PRESET_NONE, 1'b1, 1'b0, 0));
    send_tick(make_tick(1'b0, 0, PRESET_NONE, 1'b1, 1'b0, -18));
    send_tick(make_tick(1'b0, 0, PRESET_NONE, 1'b0, 1'b1, 30));
    wait_for_drain();
  endtask

  task automatic run_random_phase(input int idle_pct, input int stall_pct, input int n);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int setting = 0; setting < 2; setting++) begin
      write_preset(REG_PRESET_0, random_position());
      write_preset(REG_PRESET_1, random_position());
      write_preset(REG_PRESET_2, random_position());
      write_preset(REG_PRESET_3, random_position());
      // stretch with no idling on either side
      recv_stall_pct = 0;
      send_idle_pct  = 0;
      for (int i = 0; i < n / 8; i++) send_tick(random_tick());
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      for (int i = n / 8; i < n; i++) send_tick(random_tick());
      wait_for_drain();
    end
  endtask

  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_off_left  = 60;
    for (int i = 0; i < 40; i++) send_tick(random_tick());
    // sender stops until every word has come back
    wait_for_drain();
    for (int i = 0; i < 10; i++) send_tick(random_tick());
    wait_for_drain();
  endtask

  initial begin
    clear_controller();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_selection_and_brake();
    test_preset_extremes();
    run_random_phase(0, 0, 220);
    run_random_phase(79, 0, 220);
    run_random_phase(0, 79, 220);
    run_random_phase(35, 35, 220);
    test_backpressure();
    repeat (10) @(negedge clk);
    if (mismatch_count == 0 && drive_due_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
